### hdl/rgc_pkg.sv
// ----------------------------------------------------------------------------
// rgc_pkg
// Types, codes and constants shared by the reject gate controller modules.
// ----------------------------------------------------------------------------
package rgc_pkg;

	localparam int QUEUE_SLOTS_DEF = 4;
	localparam int NUM_PINS        = 3;

	localparam int PIN_ENTRY = 0;
	localparam int PIN_EXIT  = 1;
	localparam int PIN_CAM   = 2;

	// saturation value of the debounce counters
	localparam logic [7:0] COUNT_CAP = 8'd200;

	localparam logic [7:0]  DEBOUNCE_PERIOD_RST    = 8'd11;
	localparam logic [7:0]  DEBOUNCE_THRESHOLD_RST = 8'd30;
	localparam logic [15:0] CAMERA_WINDOW_RST      = 16'd2000;
	localparam logic [15:0] PULSE_LENGTH_RST       = 16'd500;

	typedef enum logic [1:0] {
		CFG_DEBOUNCE_PERIOD    = 2'd0,
		CFG_DEBOUNCE_THRESHOLD = 2'd1,
		CFG_CAMERA_WINDOW      = 2'd2,
		CFG_PULSE_LENGTH       = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		PUSH_NONE    = 2'd0,
		PUSH_PASS    = 2'd1,
		PUSH_REJECT  = 2'd2,
		PUSH_DROPPED = 2'd3
	} push_event_t;

	typedef enum logic [1:0] {
		POP_NONE   = 2'd0,
		POP_PASS   = 2'd1,
		POP_REJECT = 2'd2,
		POP_EMPTY  = 2'd3
	} pop_event_t;

	typedef struct packed {
		logic entry_level;
		logic exit_level;
		logic camera_error_level;
	} in_item_t;

	typedef struct packed {
		logic       relay_on;
		logic [1:0] push_event;
		logic [1:0] pop_event;
		logic [1:0] queue_count;
		logic       window_open;
	} out_item_t;

	// one bit per debounced pin: edge available, or edge consumed
	typedef struct packed {
		logic entry;
		logic exit;
		logic cam;
	} pin_edges_t;

endpackage

### hdl/inspection_reject_gate_controller.sv
// ----------------------------------------------------------------------------
// inspection_reject_gate_controller
// Debounced sensor sequencing, verdict queue and reject relay control.
// ----------------------------------------------------------------------------
// Each accepted transaction is one millisecond tick carrying the three raw
// active-low pin levels; it produces exactly one result transaction holding
// the relay drive, the push and pop events, the queue fill and the window
// flag after that tick. The whole tick update is one combinational pass over
// the state registers, so a transaction is taken every clock cycle unless
// in_stall is high; its result is registered in the output register, or in
// the skid entry behind it while a stalled result holds the output register.
// in_stall rises only when both are occupied. Write the configuration
// registers only while no transaction is in flight.
module inspection_reject_gate_controller
	import rgc_pkg::*;
#(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_write_en,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [7:0]  debounce_period_q;
	logic [7:0]  debounce_threshold_q;
	logic [15:0] camera_window_q;
	logic [15:0] pulse_length_q;

	logic       accept;
	logic       buf_full;
	pin_edges_t edges, take;
	out_item_t  result;

	assign in_stall = buf_full;
	assign accept   = in_valid && !buf_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_period_q    <= DEBOUNCE_PERIOD_RST;
			debounce_threshold_q <= DEBOUNCE_THRESHOLD_RST;
			camera_window_q      <= CAMERA_WINDOW_RST;
			pulse_length_q       <= PULSE_LENGTH_RST;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_DEBOUNCE_PERIOD:    debounce_period_q    <= cfg_data[7:0];
				CFG_DEBOUNCE_THRESHOLD: debounce_threshold_q <= cfg_data[7:0];
				CFG_CAMERA_WINDOW:      camera_window_q      <= cfg_data;
				CFG_PULSE_LENGTH:       pulse_length_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	rgc_debounce u_debounce (
		.clk                (clk),
		.arst_n             (arst_n),
		.advance            (accept),
		.levels             (in_data),
		.debounce_period    (debounce_period_q),
		.debounce_threshold (debounce_threshold_q),
		.edges              (edges),
		.taken              (take)
	);

	rgc_core #(
		.QUEUE_SLOTS (QUEUE_SLOTS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (accept),
		.edges         (edges),
		.take          (take),
		.camera_window (camera_window_q),
		.pulse_length  (pulse_length_q),
		.result        (result)
	);

	rgc_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

### hdl/rgc_debounce.sv
// ----------------------------------------------------------------------------
// rgc_debounce
// Shared prescaler and per-pin saturating debounce counters with edge marks.
// ----------------------------------------------------------------------------
module rgc_debounce
	import rgc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       advance,
	input  in_item_t   levels,
	input  logic [7:0] debounce_period,
	input  logic [7:0] debounce_threshold,
	output pin_edges_t edges,
	input  pin_edges_t taken
);

	logic [7:0]          presc_q, presc_d, presc_inc;
	logic                step;
	logic [7:0]          cnt_q [NUM_PINS];
	logic [7:0]          cnt_d [NUM_PINS];
	logic [7:0]          cnt_inc [NUM_PINS];
	logic [NUM_PINS-1:0] seen_q, seen_d;
	logic [NUM_PINS-1:0] active_q, active_d;
	logic [NUM_PINS-1:0] taken_q, taken_d, taken_v;
	logic [NUM_PINS-1:0] lv, avail;

	always_comb begin
		lv[PIN_ENTRY] = levels.entry_level;
		lv[PIN_EXIT]  = levels.exit_level;
		lv[PIN_CAM]   = levels.camera_error_level;

		presc_inc = presc_q + 8'd1;
		step      = (presc_inc >= debounce_period);
		presc_d   = step ? 8'd0 : presc_inc;

		for (int i = 0; i < NUM_PINS; i++) begin
			cnt_d[i]    = cnt_q[i];
			seen_d[i]   = seen_q[i];
			active_d[i] = active_q[i];
			taken_d[i]  = taken_q[i];
			cnt_inc[i]  = (cnt_q[i] < COUNT_CAP) ? cnt_q[i] + 8'd1 : cnt_q[i];
			if (step) begin
				if (!lv[i]) begin
					if (seen_q[i]) begin
						cnt_d[i] = cnt_inc[i];
						if (cnt_inc[i] > debounce_threshold)
							active_d[i] = 1'b1;
					end else begin
						seen_d[i] = 1'b1;
					end
				end else begin
					// pin released: drop everything
					cnt_d[i]    = 8'd0;
					seen_d[i]   = 1'b0;
					active_d[i] = 1'b0;
					taken_d[i]  = 1'b0;
				end
			end
			avail[i] = active_d[i] & ~taken_d[i];
		end

		edges.entry = avail[PIN_ENTRY];
		edges.exit  = avail[PIN_EXIT];
		edges.cam   = avail[PIN_CAM];

		taken_v[PIN_ENTRY] = taken.entry;
		taken_v[PIN_EXIT]  = taken.exit;
		taken_v[PIN_CAM]   = taken.cam;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presc_q  <= '0;
			seen_q   <= '0;
			active_q <= '0;
			taken_q  <= '0;
			for (int i = 0; i < NUM_PINS; i++)
				cnt_q[i] <= '0;
		end else if (advance) begin
			presc_q  <= presc_d;
			seen_q   <= seen_d;
			active_q <= active_d;
			taken_q  <= taken_d | taken_v;
			for (int i = 0; i < NUM_PINS; i++)
				cnt_q[i] <= cnt_d[i];
		end
	end

endmodule

### hdl/rgc_core.sv
// ----------------------------------------------------------------------------
// rgc_core
// Camera window, verdict ring queue and relay pulse timer.
// ----------------------------------------------------------------------------
module rgc_core
	import rgc_pkg::*;
#(
	parameter int QUEUE_SLOTS = QUEUE_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  pin_edges_t  edges,
	output pin_edges_t  take,
	input  logic [15:0] camera_window,
	input  logic [15:0] pulse_length,
	output out_item_t   result
);

	localparam int PTR_W = $clog2(QUEUE_SLOTS);
	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);
	localparam logic [PTR_W+1:0] SLOTS_W   = (PTR_W+2)'(QUEUE_SLOTS);

	logic             waiting_q, waiting_d;
	logic             fixed_q, fixed_d;
	logic [15:0]      wtimer_q, wtimer_d;
	logic [15:0]      ptimer_q, ptimer_d;
	logic             pactive_q, pactive_d;
	logic             relay_q, relay_d;
	logic [PTR_W-1:0] wp_q, wp_d, wp_next;
	logic [PTR_W-1:0] rp_q, rp_d, rp_next;
	logic             queue_q [QUEUE_SLOTS];

	logic             started, pstarted;
	logic             push_en, push_val, push_ok, head;
	logic [1:0]       push_code, pop_code;
	logic [PTR_W+1:0] cnt_wide;

	always_comb begin
		take       = '0;
		take.entry = edges.entry;
		take.exit  = edges.exit;

		waiting_d = waiting_q;
		fixed_d   = fixed_q;
		wtimer_d  = wtimer_q;
		ptimer_d  = ptimer_q;
		pactive_d = pactive_q;
		relay_d   = relay_q;
		rp_d      = rp_q;
		push_en   = 1'b0;
		push_val  = 1'b0;
		pstarted  = 1'b0;
		pop_code  = POP_NONE;

		// entry edge restarts the window, any pending verdict is lost
		started = edges.entry;
		if (started) begin
			waiting_d = 1'b1;
			fixed_d   = 1'b0;
			wtimer_d  = '0;
		end

		if (waiting_d) begin
			if (edges.cam) begin
				take.cam  = 1'b1;
				push_en   = 1'b1;
				push_val  = 1'b1;
				fixed_d   = 1'b1;
				waiting_d = 1'b0;
			end else if (!started) begin
				if (wtimer_q >= camera_window) begin
					if (!fixed_q) begin
						push_en = 1'b1;
						fixed_d = 1'b1;
					end
					waiting_d = 1'b0;
				end else begin
					wtimer_d = wtimer_q + 16'd1;
				end
			end
		end

		wp_next = (wp_q == LAST_SLOT) ? '0 : wp_q + PTR_W'(1);
		rp_next = (rp_q == LAST_SLOT) ? '0 : rp_q + PTR_W'(1);
		push_ok = push_en && (wp_next != rp_q);
		wp_d    = push_ok ? wp_next : wp_q;

		if (!push_en)
			push_code = PUSH_NONE;
		else if (!push_ok)
			push_code = PUSH_DROPPED;
		else if (push_val)
			push_code = PUSH_REJECT;
		else
			push_code = PUSH_PASS;

		// forward a verdict pushed into an empty queue in the same tick
		head = (push_ok && (wp_q == rp_q)) ? push_val : queue_q[rp_q];

		if (edges.exit) begin
			if (rp_q == wp_d) begin
				pop_code = POP_EMPTY;
			end else begin
				rp_d = rp_next;
				if (head) begin
					relay_d   = 1'b0;
					pactive_d = 1'b0;
					pop_code  = POP_REJECT;
				end else begin
					relay_d   = 1'b1;
					pactive_d = 1'b1;
					ptimer_d  = '0;
					pstarted  = 1'b1;
					pop_code  = POP_PASS;
				end
			end
		end

		if (pactive_d && !pstarted) begin
			if (ptimer_q >= pulse_length) begin
				pactive_d = 1'b0;
				relay_d   = 1'b0;
			end else begin
				ptimer_d = ptimer_q + 16'd1;
			end
		end

		cnt_wide = {2'b00, wp_d} + ((wp_d < rp_d) ? SLOTS_W : '0) - {2'b00, rp_d};

		result.relay_on    = relay_d;
		result.push_event  = push_code;
		result.pop_event   = pop_code;
		result.queue_count = cnt_wide[1:0];
		result.window_open = waiting_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			waiting_q <= 1'b0;
			fixed_q   <= 1'b0;
			wtimer_q  <= '0;
			ptimer_q  <= '0;
			pactive_q <= 1'b0;
			relay_q   <= 1'b0;
			wp_q      <= '0;
			rp_q      <= '0;
		end else if (advance) begin
			waiting_q <= waiting_d;
			fixed_q   <= fixed_d;
			wtimer_q  <= wtimer_d;
			ptimer_q  <= ptimer_d;
			pactive_q <= pactive_d;
			relay_q   <= relay_d;
			wp_q      <= wp_d;
			rp_q      <= rp_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push_ok)
			queue_q[wp_q] <= push_val;
	end

endmodule

### hdl/rgc_out_buf.sv
// ----------------------------------------------------------------------------
// rgc_out_buf
// Result register with a skid entry, so one more input is taken under stall.
// ----------------------------------------------------------------------------
module rgc_out_buf
	import rgc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_item_t push_data,
	output logic      full,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	logic      main_valid_q, skid_valid_q;
	out_item_t main_q, skid_q;
	logic      drain;

	assign drain     = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (drain)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (main_valid_q && !drain)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end else if (drain) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (drain)
				main_q <= skid_q;
		end else if (push) begin
			if (main_valid_q && !drain)
				skid_q <= push_data;
			else
				main_q <= push_data;
		end
	end

endmodule
